// ----- design/pure_pursuit_steering_core_macros.svh -----
// Assertion macros for the steering core
`ifndef PURE_PURSUIT_STEERING_CORE_MACROS_SVH
`define PURE_PURSUIT_STEERING_CORE_MACROS_SVH

// Check a property on every clock outside reset
`define PPSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds
`define PPSC_NEVER(lbl, cond, msg) \
	`PPSC_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/ppsc_pkg.sv -----
// Shared constants, types and tables of the steering core
`default_nettype none
package ppsc_pkg;
	localparam int PATH_DEPTH   = 1024;
	localparam int CORDIC_STEPS = 16;
	localparam int IDX_W        = $clog2(PATH_DEPTH);
	localparam int CNT_W        = IDX_W + 1;
	localparam int SCAN_W       = (CNT_W > 11) ? CNT_W : 11;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CW           = 44;
	localparam int ZW           = 34;

	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_LOOKAHEAD = 2'd0,
		REG_SPEED_MAX = 2'd1,
		REG_SPEED_MIN = 2'd2,
		REG_TURN_MAX  = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CM_VECTOR = 1'b0,
		CM_ROTATE = 1'b1
	} cmode_t;

	typedef struct packed {
		logic   start;
		cmode_t mode;
	} cordic_ctl_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- design/ppsc_ram.sv -----
// Generic simple dual-port RAM with registered read
`default_nettype none
module ppsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- design/ppsc_cordic.sv -----
// Iterative CORDIC: vector magnitude and angle, or sine of an angle
`default_nettype none
module ppsc_cordic (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ppsc_pkg::cordic_ctl_t      ctl,
	input  wire logic signed [32:0]         vec_x,
	input  wire logic signed [32:0]         vec_y,
	input  wire logic signed [31:0]         angle,
	output logic                            done,
	output logic [41:0]                     len,
	output logic [31:0]                     ang,
	output logic signed [31:0]              sin_val
);
	import ppsc_pkg::*;

	typedef enum logic [2:0] {C_IDLE, C_NORM, C_ITER, C_GAIN, C_FIN} cstate_t;

	localparam logic signed [ZW-1:0] HALF_PI = ZW'(64'sd1073741824);
	localparam logic signed [ZW-1:0] FULL_PI = ZW'(64'sd2147483648);

	cstate_t                state_q;
	cmode_t                 mode_q;
	logic signed [CW-1:0]   x_q, y_q;
	logic signed [ZW-1:0]   z_q;
	logic [STEP_W-1:0]      i_q;
	logic [5:0]             k_q;
	logic [63:0]            prod_q;
	logic [41:0]            len_q;
	logic                   done_q;

	logic signed [CW-1:0]   ax, ay, m, xs, ys, xc;
	logic signed [ZW-1:0]   at, ae, z0;
	logic [6:0]             sh;
	logic                   dir;

	always_comb begin
		ax = x_q[CW-1] ? -x_q : x_q;
		ay = y_q[CW-1] ? -y_q : y_q;
		m  = (ax > ay) ? ax : ay;
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		xc = x_q[CW-1] ? '0 : x_q;
		at = $signed({2'b00, atan_entry(5'(i_q))});
		ae = ZW'(angle);
		if (ae > HALF_PI) begin
			z0 = FULL_PI - ae;
		end else if (ae < -HALF_PI) begin
			z0 = -FULL_PI - ae;
		end else begin
			z0 = ae;
		end
		dir = (mode_q == CM_VECTOR) ? (y_q > 0) : (z_q >= 0);
		sh  = 7'd22 + 7'(k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			mode_q  <= CM_VECTOR;
			done_q  <= 1'b0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (ctl.start) begin
						mode_q <= ctl.mode;
						i_q    <= '0;
						k_q    <= '0;
						if (ctl.mode == CM_VECTOR) begin
							x_q     <= CW'(vec_x);
							y_q     <= CW'(vec_y);
							z_q     <= '0;
							state_q <= C_NORM;
						end else begin
							x_q     <= CW'({1'b0, INV_GAIN_Q30});
							y_q     <= '0;
							z_q     <= z0;
							state_q <= C_ITER;
						end
					end
				end
				C_NORM: begin
					if (m == 0) begin
						len_q   <= '0;
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end else if (m < (CW'(1) <<< 39)) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
						k_q <= k_q + 6'd1;
					end else begin
						if (x_q[CW-1]) begin
							if (!y_q[CW-1]) begin
								x_q <= y_q;
								y_q <= -x_q;
								z_q <= HALF_PI;
							end else begin
								x_q <= -y_q;
								y_q <= x_q;
								z_q <= -HALF_PI;
							end
						end
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (mode_q == CM_VECTOR) begin
						if (dir) begin
							x_q <= x_q + ys;
							y_q <= y_q - xs;
							z_q <= z_q + at;
						end else begin
							x_q <= x_q - ys;
							y_q <= y_q + xs;
							z_q <= z_q - at;
						end
					end else begin
						if (dir) begin
							x_q <= x_q - ys;
							y_q <= y_q + xs;
							z_q <= z_q - at;
						end else begin
							x_q <= x_q + ys;
							y_q <= y_q - xs;
							z_q <= z_q + at;
						end
					end
					i_q <= i_q + STEP_W'(1);
					if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= C_GAIN;
					end
				end
				C_GAIN: begin
					if (mode_q == CM_VECTOR) begin
						prod_q  <= 64'(xc[41:10]) * 64'(INV_GAIN_Q32);
						state_q <= C_FIN;
					end else begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				C_FIN: begin
					len_q   <= 42'(prod_q >> sh);
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign len     = len_q;
	assign ang     = z_q[31:0];
	assign sin_val = y_q[31:0];
endmodule
`default_nettype wire

// ----- design/ppsc_div.sv -----
// Restoring divider, one quotient bit per cycle
`default_nettype none
module ppsc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [64:0] rem_q;
	logic [63:0] quo_q, div_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] shr;
	logic        ge;

	always_comb begin
		shr = {rem_q[63:0], quo_q[63]};
		ge  = shr >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				div_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? (shr - {1'b0, div_q}) : shr;
				quo_q <= {quo_q[62:0], ge};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ----- design/pure_pursuit_steering_core.sv -----
// Pure pursuit steering core: path store, nearest and target search, steering law
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tuser kind, tdata pose or waypoint
// m_       out  m_tvalid/m_tready  tdata speed, turn rate, index, aligned
// cfg_     in   cfg_we             cfg_index, cfg_data
//
// Clear and append complete as they are taken; kinds with no result leave no trace.
// A query runs the window and target scans, CORDIC vectoring and normalize, then
// CORDIC sine and divider unless it turns in place or at zero distance; the path scan
// streams one waypoint per cycle from the path RAM through a three-stage distance pipe.
// Reset clears the waypoint count and loads the config defaults; the path RAM is not cleared.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
`include "pure_pursuit_steering_core_macros.svh"
module pure_pursuit_steering_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // pos_x, pos_y, heading, prior_closest, was_aligned
	input  wire logic [1:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // linear_speed, angular_speed, nearest_index, now_aligned
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import ppsc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WIN, ST_TGT, ST_LAST_RD, ST_LAST_WAIT, ST_VEC, ST_ALIGN,
		ST_SPD, ST_CLAMP, ST_SIN, ST_MUL, ST_DIV, ST_RESULT
	} state_t;

	state_t               state_q;
	logic [30:0]          look_q, tmax_q;
	logic signed [31:0]   smax_q, smin_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [31:0]   px_q, py_q;
	logic [15:0]          head_q;
	logic                 algn_q;
	logic [61:0]          look2_q;
	logic [SCAN_W-1:0]    addr_q, end_q, closest_q;
	logic                 issue_q;
	logic [63:0]          best_q;
	logic signed [31:0]   tx_q, ty_q;
	logic signed [31:0]   a_q;
	logic signed [27:0]   f_q;
	logic signed [59:0]   sprod_q;
	logic signed [31:0]   v_q, w_q;
	logic signed [63:0]   nprod_q;
	logic                 aligned_q;
	logic                 cstart_q, dstart_q;
	cmode_t               cmode_q;
	logic                 m_tvalid_q;
	logic [79:0]          m_tdata_q;

	logic                 v_s1, v_s2, v_s3;
	logic [SCAN_W-1:0]    idx_s1, idx_s2, idx_s3;
	logic [31:0]          adx_s2, ady_s2;
	logic [63:0]          wxy_s2, wxy_s3;
	logic [63:0]          sqx_s3, sqy_s3;

	logic                 accept, ram_we;
	logic [IDX_W-1:0]     raddr;
	logic [63:0]          rdata;
	kind_t                kind;
	logic [9:0]           prior;
	logic [SCAN_W-1:0]    win_start, win_end, prior_w, cnt_w;
	logic signed [32:0]   dx1, dy1;
	logic [32:0]          adx1, ady1;
	logic [64:0]          sum3;
	logic [63:0]          d3;
	logic                 hit, drained, flush;
	cordic_ctl_t          cctl;
	logic signed [32:0]   vec_x, vec_y;
	logic                 c_done;
	logic [41:0]          c_len;
	logic [31:0]          c_ang;
	logic signed [31:0]   c_sin;
	logic                 d_done;
	logic [63:0]          d_quo;
	logic [31:0]          diff;
	logic [32:0]          absa;
	logic [34:0]          abs7;
	logic                 rot, a_pos;
	logic signed [35:0]   tdiff, vdes, vlim, vfin;
	logic signed [63:0]   num2, mag;
	logic [63:0]          den;
	logic [31:0]          qlim;
	logic signed [31:0]   tmax_s;

	assign kind     = kind_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign ram_we   = accept && (kind == KIND_APPEND) && (cnt_q < CNT_W'(PATH_DEPTH));
	assign prior    = s_tdata[89:80];
	assign tmax_s   = $signed({1'b0, tmax_q});

	always_comb begin
		prior_w   = SCAN_W'(prior);
		cnt_w     = SCAN_W'(cnt_q);
		win_start = (prior >= 10'd5) ? (prior_w - SCAN_W'(5)) : '0;
		win_end   = ((prior_w + SCAN_W'(30)) < cnt_w) ? (prior_w + SCAN_W'(30)) : cnt_w;
		raddr     = (state_q == ST_LAST_RD) ? IDX_W'(cnt_q - CNT_W'(1)) : addr_q[IDX_W-1:0];
		dx1  = $signed({rdata[31], rdata[31:0]}) - $signed({px_q[31], px_q});
		dy1  = $signed({rdata[63], rdata[63:32]}) - $signed({py_q[31], py_q});
		adx1 = dx1[32] ? 33'(-dx1) : 33'(dx1);
		ady1 = dy1[32] ? 33'(-dy1) : 33'(dy1);
		sum3 = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		d3   = sum3[64] ? '1 : sum3[63:0];
		hit  = d3 >= {2'b00, look2_q};
		drained = !issue_q && !v_s1 && !v_s2 && !v_s3;
		flush   = (state_q == ST_TGT) && v_s3 && hit;
		vec_x = $signed({tx_q[31], tx_q}) - $signed({px_q[31], px_q});
		vec_y = $signed({ty_q[31], ty_q}) - $signed({py_q[31], py_q});
		cctl  = '{start: cstart_q, mode: cmode_q};
		diff  = c_ang - {head_q, 16'h0000};
		absa  = diff[31] ? (33'h1_0000_0000 - {1'b0, diff}) : {1'b0, diff};
		abs7  = 35'({absa, 3'b000} - {3'b000, absa});
		rot   = !algn_q && (abs7 > 35'h1_0000_0000);
		a_pos = !diff[31] && (diff != 32'd0);
		tdiff = 36'sh1_0000_0000 - $signed({1'b0, abs7});
		vdes  = 36'(sprod_q >>> 24);
		vlim  = (vdes < 36'(smax_q)) ? vdes : 36'(smax_q);
		vfin  = (vlim < 36'(smin_q)) ? 36'(smin_q) : vlim;
		num2  = nprod_q <<< 1;
		mag   = nprod_q[63] ? -num2 : num2;
		den   = {8'h00, c_len, 14'h0000};
		qlim  = (d_quo > {33'd0, tmax_q}) ? {1'b0, tmax_q} : d_quo[31:0];
	end

	ppsc_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH)) u_path (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({s_tdata[63:32], s_tdata[31:0]}),
		.raddr (raddr),
		.rdata (rdata)
	);

	ppsc_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cctl),
		.vec_x   (vec_x),
		.vec_y   (vec_y),
		.angle   (a_q),
		.done    (c_done),
		.len     (c_len),
		.ang     (c_ang),
		.sin_val (c_sin)
	);

	ppsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dstart_q),
		.dividend (mag),
		.divisor  (den),
		.done     (d_done),
		.quotient (d_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue_q && !flush;
			v_s2 <= v_s1 && !flush;
			v_s3 <= v_s2 && !flush;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		adx_s2 <= adx1[31:0];
		ady_s2 <= ady1[31:0];
		wxy_s2 <= rdata;
		idx_s3 <= idx_s2;
		wxy_s3 <= wxy_s2;
		sqx_s3 <= 64'(adx_s2) * 64'(adx_s2);
		sqy_s3 <= 64'(ady_s2) * 64'(ady_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			look_q     <= 31'd32768;
			smax_q     <= 32'sd14418;
			smin_q     <= 32'sd0;
			tmax_q     <= 31'd65536;
			cnt_q      <= '0;
			issue_q    <= 1'b0;
			cstart_q   <= 1'b0;
			dstart_q   <= 1'b0;
			cmode_q    <= CM_VECTOR;
			m_tvalid_q <= 1'b0;
		end else begin
			cstart_q <= 1'b0;
			dstart_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_LOOKAHEAD: look_q <= cfg_data[30:0];
					REG_SPEED_MAX: smax_q <= cfg_data;
					REG_SPEED_MIN: smin_q <= cfg_data;
					REG_TURN_MAX:  tmax_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (issue_q) begin
				addr_q <= addr_q + SCAN_W'(1);
				if ((addr_q + SCAN_W'(1)) >= end_q) begin
					issue_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_CLEAR: cnt_q <= '0;
							KIND_APPEND: begin
								if (ram_we) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							KIND_QUERY: begin
								px_q      <= s_tdata[31:0];
								py_q      <= s_tdata[63:32];
								head_q    <= s_tdata[79:64];
								algn_q    <= s_tdata[90];
								look2_q   <= 62'(look_q) * 62'(look_q);
								closest_q <= win_start;
								best_q    <= '1;
								addr_q    <= win_start;
								end_q     <= win_end;
								issue_q   <= win_start < win_end;
								if (cnt_q == '0) begin
									v_q       <= '0;
									w_q       <= '0;
									closest_q <= '0;
									aligned_q <= 1'b0;
									issue_q   <= 1'b0;
									state_q   <= ST_RESULT;
								end else begin
									state_q <= ST_WIN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_WIN: begin
					if (v_s3 && (d3 < best_q)) begin
						best_q    <= d3;
						closest_q <= idx_s3;
					end
					if (drained) begin
						addr_q  <= closest_q;
						end_q   <= cnt_w;
						issue_q <= closest_q < cnt_w;
						state_q <= ST_TGT;
					end
				end
				ST_TGT: begin
					if (flush) begin
						tx_q     <= wxy_s3[31:0];
						ty_q     <= wxy_s3[63:32];
						issue_q  <= 1'b0;
						cstart_q <= 1'b1;
						cmode_q  <= CM_VECTOR;
						state_q  <= ST_VEC;
					end else if (drained) begin
						state_q <= ST_LAST_RD;
					end
				end
				ST_LAST_RD: state_q <= ST_LAST_WAIT;
				ST_LAST_WAIT: begin
					tx_q     <= rdata[31:0];
					ty_q     <= rdata[63:32];
					cstart_q <= 1'b1;
					cmode_q  <= CM_VECTOR;
					state_q  <= ST_VEC;
				end
				ST_VEC: begin
					if (c_done) begin
						state_q <= ST_ALIGN;
					end
				end
				ST_ALIGN: begin
					a_q <= $signed(diff);
					f_q <= 28'(tdiff >>> 8);
					if (rot) begin
						v_q       <= '0;
						w_q       <= a_pos ? tmax_s : -tmax_s;
						aligned_q <= 1'b0;
						state_q   <= ST_RESULT;
					end else begin
						aligned_q <= 1'b1;
						state_q   <= ST_SPD;
					end
				end
				ST_SPD: begin
					sprod_q <= 60'(smax_q) * 60'(f_q);
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					v_q <= vfin[31:0];
					if (c_len == '0) begin
						w_q     <= '0;
						state_q <= ST_RESULT;
					end else begin
						cstart_q <= 1'b1;
						cmode_q  <= CM_ROTATE;
						state_q  <= ST_SIN;
					end
				end
				ST_SIN: begin
					if (c_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					nprod_q  <= 64'(v_q) * 64'(c_sin);
					dstart_q <= 1'b1;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (d_done) begin
						w_q     <= nprod_q[63] ? -$signed(qlim) : $signed(qlim);
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {5'b00000, aligned_q, closest_q[9:0], w_q, v_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PPSC_ASSERT(a_count_bound, cnt_q <= CNT_W'(PATH_DEPTH), "waypoint count past path depth")
	`PPSC_NEVER(a_idle_scan, (state_q == ST_IDLE) && (issue_q || v_s1 || v_s2 || v_s3), "scan active while idle")
	`PPSC_ASSERT(a_result_load, (state_q == ST_RESULT) && !m_tvalid_q |=> m_tvalid_q && (state_q == ST_IDLE), "result not loaded")
endmodule
`default_nettype wire
